// ----- rtl/dec_pkg.sv -----
// ----------------------------------------------------------------------------
// dec_pkg
// Shared types and constants of the debounced encoder edge counter.
// ----------------------------------------------------------------------------
package dec_pkg;

	localparam int TICKS_W = 4;
	localparam int OUT_W = 16;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;
	localparam int REG_IDX_W = 2;

	localparam logic [TICKS_W-1:0] TICKS_RESET = 4'd2;

	typedef enum logic {
		OP_POLL = 1'b0,
		OP_TAKE = 1'b1
	} op_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_QUAD_MODE = 2'd0,
		REG_INVERT    = 2'd1,
		REG_TICKS     = 2'd2,
		REG_UNUSED    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic poll;
		logic take;
		logic up;
		logic down;
	} delta_ctrl_t;

endpackage

// ----- rtl/dec_channel.sv -----
// ----------------------------------------------------------------------------
// dec_channel
// Low-run counter and qualified rise detector for one encoder pin.
// ----------------------------------------------------------------------------
module dec_channel
	import dec_pkg::*;
#(
	parameter int COUNT_WIDTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               level,
	input  logic [TICKS_W-1:0] rise_threshold,
	output logic               fire
);

	localparam int CMP_W = (COUNT_WIDTH + 1 > TICKS_W) ? COUNT_WIDTH + 1 : TICKS_W;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	logic                   last_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] count_next;
	logic [CMP_W-1:0]       run_len;

	assign run_len = CMP_W'(count_q) + CMP_W'(1);
	assign fire = en && level && !last_q && (run_len >= CMP_W'(rise_threshold));

	always_comb begin
		count_next = '0;
		if (!level && !last_q) begin
			count_next = (count_q != COUNT_MAX) ? count_q + COUNT_WIDTH'(1) : count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= 1'b1;
			count_q <= '0;
		end else if (en) begin
			last_q  <= level;
			count_q <= count_next;
		end
	end

endmodule

// ----- rtl/dec_delta.sv -----
// ----------------------------------------------------------------------------
// dec_delta
// Saturating delta accumulator with the take-and-clear path.
// ----------------------------------------------------------------------------
module dec_delta
	import dec_pkg::*;
#(
	parameter int DELTA_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  delta_ctrl_t             ctrl,
	input  logic                    invert_direction,
	output logic signed [OUT_W-1:0] taken
);

	localparam int EXT_W = (DELTA_WIDTH > OUT_W) ? DELTA_WIDTH : OUT_W;
	localparam logic signed [DELTA_WIDTH-1:0] ACC_MAX = {1'b0, {(DELTA_WIDTH-1){1'b1}}};
	localparam logic signed [DELTA_WIDTH-1:0] ACC_MIN = {1'b1, {(DELTA_WIDTH-1){1'b0}}};
	localparam logic signed [EXT_W-1:0] OUT_MAX = EXT_W'(32'sd32767);
	localparam logic signed [EXT_W-1:0] OUT_MIN = EXT_W'(-32'sd32768);

	logic signed [DELTA_WIDTH-1:0] acc_q;
	logic signed [DELTA_WIDTH-1:0] acc_next;
	logic signed [DELTA_WIDTH-1:0] d;
	logic signed [EXT_W-1:0]       d_ext;

	always_comb begin
		d = acc_q;
		if (invert_direction) begin
			d = (acc_q == ACC_MIN) ? ACC_MAX : -acc_q;
		end
		d_ext = EXT_W'(d);
		if (d_ext > OUT_MAX) begin
			taken = OUT_MAX[OUT_W-1:0];
		end else if (d_ext < OUT_MIN) begin
			taken = OUT_MIN[OUT_W-1:0];
		end else begin
			taken = d_ext[OUT_W-1:0];
		end
	end

	always_comb begin
		acc_next = acc_q;
		if (ctrl.take) begin
			acc_next = '0;
		end else if (ctrl.poll) begin
			if (ctrl.up && !ctrl.down && acc_q != ACC_MAX) begin
				acc_next = acc_q + DELTA_WIDTH'(1);
			end else if (ctrl.down && !ctrl.up && acc_q != ACC_MIN) begin
				acc_next = acc_q - DELTA_WIDTH'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			acc_q <= acc_next;
		end
	end

`ifndef ASSERT_OFF
	a_take_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.take |=> acc_q == '0)
		else $error("accumulator not cleared after a take request");
`endif

endmodule

// ----- rtl/debounced_encoder_edge_counter.sv -----
// ----------------------------------------------------------------------------
// debounced_encoder_edge_counter
// Debounced two-pin rotary encoder decoder with a saturating delta counter.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake                | Payload
// in      | to block  | in_valid / in_stall      | operation, level_a, level_b
// out     | from block| out_valid / out_stall    | taken_delta, rise_a, rise_b
// cfg     | to block  | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One request per cycle is accepted while in_stall is low; each result passes
// through the input register and then the result register.
// Reset sets both pins' last level high, clears the low counts and the delta.
// A stalled result holds the result register; the input register still takes
// one request, after which in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module debounced_encoder_edge_counter
	import dec_pkg::*;
#(
	parameter int DELTA_WIDTH = 16,
	parameter int COUNT_WIDTH = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [APB_ADDR_W-1:0]   paddr,
	input  logic [APB_DATA_W-1:0]   pwdata,
	output logic [APB_DATA_W-1:0]   prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    operation,
	input  logic                    level_a,
	input  logic                    level_b,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] taken_delta,
	output logic                    rise_a,
	output logic                    rise_b
);

	logic               quad_q;
	logic               invert_q;
	logic [TICKS_W-1:0] ticks_q;
	reg_idx_t           reg_idx;

	logic valid_s1;
	op_t  op_s1;
	logic level_a_s1;
	logic level_b_s1;

	logic                    valid_s2;
	logic signed [OUT_W-1:0] taken_s2;
	logic                    rise_a_s2;
	logic                    rise_b_s2;

	logic                    adv;
	logic                    in_acc;
	logic                    issue;
	logic                    poll_en;
	logic                    fire_a;
	logic                    fire_b;
	delta_ctrl_t             dctrl;
	logic signed [OUT_W-1:0] taken;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[REG_IDX_W+1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quad_q   <= 1'b0;
			invert_q <= 1'b0;
			ticks_q  <= TICKS_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_QUAD_MODE: quad_q <= pwdata[0];
				REG_INVERT:    invert_q <= pwdata[0];
				REG_TICKS:     ticks_q <= pwdata[TICKS_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_QUAD_MODE: prdata = APB_DATA_W'(quad_q);
			REG_INVERT:    prdata = APB_DATA_W'(invert_q);
			REG_TICKS:     prdata = APB_DATA_W'(ticks_q);
			default:       prdata = '0;
		endcase
	end

	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;
	assign issue    = valid_s1 && adv;
	assign poll_en  = issue && (op_s1 == OP_POLL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1      <= op_t'(operation);
			level_a_s1 <= level_a;
			level_b_s1 <= level_b;
		end
	end

	dec_channel #(.COUNT_WIDTH(COUNT_WIDTH)) u_chan_a (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (poll_en),
		.level          (level_a_s1),
		.rise_threshold (ticks_q),
		.fire           (fire_a)
	);

	dec_channel #(.COUNT_WIDTH(COUNT_WIDTH)) u_chan_b (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (poll_en),
		.level          (level_b_s1),
		.rise_threshold (ticks_q),
		.fire           (fire_b)
	);

	always_comb begin
		dctrl.poll = poll_en;
		dctrl.take = issue && (op_s1 == OP_TAKE);
		dctrl.up   = quad_q ? (fire_a && !level_b_s1) : fire_a;
		dctrl.down = quad_q ? (fire_a && level_b_s1) : fire_b;
	end

	dec_delta #(.DELTA_WIDTH(DELTA_WIDTH)) u_delta (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl             (dctrl),
		.invert_direction (invert_q),
		.taken            (taken)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			taken_s2  <= (op_s1 == OP_TAKE) ? taken : '0;
			rise_a_s2 <= fire_a;
			rise_b_s2 <= fire_b;
		end
	end

	assign out_valid   = valid_s2;
	assign taken_delta = taken_s2;
	assign rise_a      = rise_a_s2;
	assign rise_b      = rise_b_s2;

`ifndef ASSERT_OFF
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled while the pipeline has room");
	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> out_valid)
		else $error("processed request did not reach the result register");
	a_rise_only_on_poll: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (rise_a || rise_b)) |-> taken_delta == '0)
		else $error("rise reported together with a taken delta");
`endif

endmodule
